/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, removed when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_RST(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define ASSERT_ANY(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(name, clk, rst_n, prop, msg)
`define ASSERT_ANY(name, clk, prop, msg)
`endif

`endif

/* src/ptb_pkg.sv */
// ----------------------------------------------------------------------------
// Periodic timer bank package
// Sizes, mode codes and the command bundle broadcast to the timer cells.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int MAX_TICKS   = 16;
  localparam int IDX_W       = $clog2(MAX_TICKS);

  localparam int MODE_W     = 2;
  localparam int SLOT_W     = 3;
  localparam int PERIOD_W   = 16;
  localparam int TCOUNT_W   = 5;
  localparam int MASK_W     = 8;
  localparam int TIDX_W     = 4;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_PAD_W  = OUT_DATA_W - MASK_W - TIDX_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_REG   = 2'd1,
    MODE_UNREG = 2'd2
  } mode_e;

  typedef struct packed {
    logic                   load;
    logic                   unload;
    logic                   tick;
    logic [COUNT_WIDTH-1:0] period;
  } cmd_t;

endpackage

/* src/ptb_cell.sv */
// ----------------------------------------------------------------------------
// Timer cell
// One countdown slot; appends its fire bit to the mask handed down the row.
// ----------------------------------------------------------------------------
module ptb_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ptb_pkg::cmd_t                  cmd_i,
  input  logic                           sel_i,
  input  logic [ptb_pkg::NUM_SLOTS-1:0]  mask_i,
  output logic [ptb_pkg::NUM_SLOTS-1:0]  mask_o
);

  logic                            armed_q;
  logic [ptb_pkg::COUNT_WIDTH-1:0] remaining_q;
  logic [ptb_pkg::COUNT_WIDTH-1:0] reload_q;
  logic [ptb_pkg::COUNT_WIDTH-1:0] dec;
  logic                            fire;

  assign dec    = remaining_q - ptb_pkg::COUNT_WIDTH'(1);
  assign fire   = cmd_i.tick && armed_q && (dec == '0);
  assign mask_o = {mask_i[ptb_pkg::NUM_SLOTS-2:0], fire};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
    end else if (sel_i && cmd_i.load) begin
      armed_q <= 1'b1;
    end else if (sel_i && cmd_i.unload) begin
      armed_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_i && cmd_i.load) begin
      reload_q    <= cmd_i.period;
      remaining_q <= cmd_i.period;
    end else if (cmd_i.tick && armed_q) begin
      remaining_q <= fire ? reload_q : dec;
    end
  end

endmodule

/* src/periodic_timer_bank_top.sv */
// ----------------------------------------------------------------------------
// Periodic timer bank
// Row of countdown timer cells driven by register, unregister and tick beats.
// ----------------------------------------------------------------------------
// Input beats carry the mode in s_axis_tuser and slot, period and tick count
// in s_axis_tdata. A register or unregister beat updates one cell and yields
// one result beat with an empty mask in the cycle after acceptance; the next
// input beat may follow in the next cycle. A tick beat with count n > 0
// (saturated to 16) yields n result beats, one per cycle while the receiver
// takes them; every cell counts down in parallel on the single shared tick
// step of the cell row. A count of 0 yields one empty-mask beat. The last
// result beat of every input beat has m_axis_tlast set. Results sit in an
// output register. A new input beat is taken only in idle, in a cycle where
// that register is empty or its beat is being accepted. When the receiver
// stalls, ticking pauses, the held beat stays put and the input waits. Reset
// disarms every slot and empties the output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module periodic_timer_bank_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // slot [2:0], period [18:3], tick_count [23:19]
  input  logic [ptb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // mode [1:0]
  input  logic [ptb_pkg::MODE_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // fired_mask [7:0], tick_index [11:8], zero [15:12]
  output logic [ptb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast
);

  typedef enum logic {
    ST_IDLE,
    ST_TICK
  } state_e;

  state_e                          state_q;
  logic                            m_valid_q;
  logic [ptb_pkg::MASK_W-1:0]      m_mask_q;
  logic [ptb_pkg::TIDX_W-1:0]      m_idx_q;
  logic                            m_last_q;
  logic [ptb_pkg::IDX_W-1:0]       idx_q;
  logic [ptb_pkg::IDX_W-1:0]       last_idx_q;

  ptb_pkg::mode_e                  mode;
  logic [ptb_pkg::SLOT_W-1:0]      slot;
  logic [ptb_pkg::PERIOD_W-1:0]    period;
  logic [ptb_pkg::TCOUNT_W-1:0]    tick_count;
  logic [ptb_pkg::TCOUNT_W-1:0]    tick_sat;
  logic [ptb_pkg::COUNT_WIDTH-1:0] period_trunc;
  logic                            s_accept;
  logic                            out_free;
  logic                            advance;
  logic                            is_batch;
  ptb_pkg::cmd_t                   cmd;
  logic [ptb_pkg::NUM_SLOTS-1:0]   chain [ptb_pkg::NUM_SLOTS+1];
  logic [ptb_pkg::NUM_SLOTS-1:0]   fired;

  assign mode         = ptb_pkg::mode_e'(s_axis_tuser);
  assign slot         = s_axis_tdata[2:0];
  assign period       = s_axis_tdata[18:3];
  assign tick_count   = s_axis_tdata[23:19];
  assign tick_sat     = (tick_count > ptb_pkg::TCOUNT_W'(ptb_pkg::MAX_TICKS))
                        ? ptb_pkg::TCOUNT_W'(ptb_pkg::MAX_TICKS) : tick_count;
  assign period_trunc = ptb_pkg::COUNT_WIDTH'(period);

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign advance       = (state_q == ST_TICK) && out_free;
  assign is_batch      = (mode == ptb_pkg::MODE_TICK) && (tick_count != '0);

  always_comb begin
    cmd.load   = s_accept && (mode == ptb_pkg::MODE_REG);
    cmd.unload = s_accept && (mode == ptb_pkg::MODE_UNREG);
    cmd.tick   = advance;
    cmd.period = (period_trunc == '0) ? ptb_pkg::COUNT_WIDTH'(1) : period_trunc;
  end

  assign chain[ptb_pkg::NUM_SLOTS] = '0;
  assign fired                     = chain[0];

  for (genvar s = 0; s < ptb_pkg::NUM_SLOTS; s++) begin : g_cell
    ptb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .sel_i  (slot == ptb_pkg::SLOT_W'(s)),
      .mask_i (chain[s+1]),
      .mask_o (chain[s])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_valid_q  <= 1'b0;
      m_mask_q   <= '0;
      m_idx_q    <= '0;
      m_last_q   <= 1'b0;
      idx_q      <= '0;
      last_idx_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            if (is_batch) begin
              state_q    <= ST_TICK;
              idx_q      <= '0;
              last_idx_q <= ptb_pkg::IDX_W'(tick_sat - ptb_pkg::TCOUNT_W'(1));
              m_valid_q  <= 1'b0;
            end else begin
              m_valid_q <= 1'b1;
              m_mask_q  <= '0;
              m_idx_q   <= '0;
              m_last_q  <= 1'b1;
            end
          end else if (m_axis_tready) begin
            m_valid_q <= 1'b0;
          end
        end
        ST_TICK: begin
          if (advance) begin
            m_valid_q <= 1'b1;
            m_mask_q  <= ptb_pkg::MASK_W'(fired);
            m_idx_q   <= ptb_pkg::TIDX_W'(idx_q);
            m_last_q  <= (idx_q == last_idx_q);
            idx_q     <= idx_q + ptb_pkg::IDX_W'(1);
            if (idx_q == last_idx_q) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{ptb_pkg::OUT_PAD_W{1'b0}}, m_idx_q, m_mask_q};
  assign m_axis_tlast  = m_last_q;

  `ASSERT_RST(a_idle_holds_last, clk_i, rst_ni,
    (state_q == ST_IDLE && m_valid_q) |-> m_last_q, "held beat in idle is not last")
  `ASSERT_RST(a_no_overwrite, clk_i, rst_ni,
    s_accept |-> (!m_valid_q || m_axis_tready), "input taken over a stalled result")
  `ASSERT_RST(a_idx_bound, clk_i, rst_ni,
    (state_q == ST_TICK) |-> (idx_q <= last_idx_q), "tick index beyond batch end")
  `ASSERT_RST(a_batch_starts, clk_i, rst_ni,
    (s_accept && is_batch) |=> (state_q == ST_TICK && idx_q == '0), "tick batch not started")

endmodule
